/* hdl/shape_fill_raster_engine_assert.svh */
// assertion macros shared by the raster engine rtl
`ifndef SHAPE_FILL_RASTER_ENGINE_ASSERT_SVH
`define SHAPE_FILL_RASTER_ENGINE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SFR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfr assertion failed");

// next-cycle implication, checked out of reset
`define SFR_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfr assertion failed");

`endif

/* hdl/sfr_pkg.sv */
// shared types, codes and helpers of the shape fill raster engine
package sfr_pkg;

    localparam int GRID_WIDTH_DEF  = 64;
    localparam int GRID_HEIGHT_DEF = 64;

    // signed working width for clamped coordinates and offsets
    localparam int COORD_W = 10;
    // squared offsets stay below 256*256
    localparam int SQ_W    = 16;
    localparam int DIST_W  = SQ_W + 1;

    typedef logic signed [COORD_W-1:0] coord_t;

    localparam logic [1:0] CMD_RECT   = 2'd0;
    localparam logic [1:0] CMD_CIRCLE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_ZERO_SIZE = 2'd1;
    localparam logic [1:0] STATUS_OUTSIDE   = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_SQ_R,
        ST_SQ_X,
        ST_LOAD,
        ST_FILL,
        ST_READ,
        ST_READ_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        SCAN_HOLD,
        SCAN_SQ_R,
        SCAN_SQ_X,
        SCAN_LOAD,
        SCAN_STEP
    } scan_op_t;

    typedef struct packed {
        scan_op_t op;
        logic     circle;
    } scan_ctrl_t;

    typedef struct packed {
        logic hit;
        logic last;
    } scan_stat_t;

    function automatic coord_t clamp_coord(input coord_t v, input coord_t hi);
        coord_t c;
        c = v;
        if (v < 0)
        begin
            c = '0;
        end
        else if (v > hi)
        begin
            c = hi;
        end
        return c;
    endfunction

endpackage

/* hdl/sfr_if.sv */
// command and result channel interfaces
interface sfr_cmd_if;
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic signed [7:0] pos_x;
    logic signed [7:0] pos_y;
    logic [7:0]        rect_width;
    logic [7:0]        rect_height;
    logic [6:0]        radius;
    logic [7:0]        fill_value;

    modport source (
        output valid, command, pos_x, pos_y, rect_width, rect_height, radius, fill_value,
        input  ready
    );
    modport sink (
        input  valid, command, pos_x, pos_y, rect_width, rect_height, radius, fill_value,
        output ready
    );
endinterface

interface sfr_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_value;
    logic [1:0] status;

    modport source (
        output valid, read_value, status,
        input  ready
    );
    modport sink (
        input  valid, read_value, status,
        output ready
    );
endinterface

/* hdl/sfr_scan_unit.sv */
// box scanner with shared squarer and incremental distance test
module sfr_scan_unit import sfr_pkg::*; #(
    parameter int CW = $clog2(GRID_WIDTH_DEF),
    parameter int RW = $clog2(GRID_HEIGHT_DEF)
) (
    input  logic          clk,
    input  scan_ctrl_t    ctrl,
    input  coord_t        x0,
    input  coord_t        x1,
    input  coord_t        y0,
    input  coord_t        y1,
    input  coord_t        cx,
    input  coord_t        cy,
    input  logic [6:0]    radius,
    output scan_stat_t    stat,
    output logic [CW-1:0] col,
    output logic [RW-1:0] row
);

    coord_t                    dx0;
    coord_t                    dy0;
    coord_t                    sq_in;
    logic signed [2*COORD_W-1:0] sq_full;
    logic [SQ_W-1:0]           sq;

    logic [SQ_W-1:0] r2_reg, r2_next;
    logic [SQ_W-1:0] dx0sq_reg, dx0sq_next;
    logic [SQ_W-1:0] dx2_reg, dx2_next;
    logic [SQ_W-1:0] dy2_reg, dy2_next;
    coord_t          dx_reg, dx_next;
    coord_t          dy_reg, dy_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;

    logic signed [SQ_W+1:0] dx2_step;
    logic signed [SQ_W+1:0] dy2_step;
    logic [DIST_W-1:0]      dist_sum;
    logic                   col_last;
    logic                   row_last;

    assign dx0 = x0 - cx;
    assign dy0 = y0 - cy;

    // one squarer serves r, the row start offset and the first column offset
    always_comb
    begin
        case (ctrl.op)
            SCAN_SQ_R: sq_in = coord_t'({3'b000, radius});
            SCAN_SQ_X: sq_in = dx0;
            default:   sq_in = dy0;
        endcase
    end

    assign sq_full = sq_in * sq_in;
    assign sq      = sq_full[SQ_W-1:0];

    // (d+1)^2 = d^2 + 2d + 1
    assign dx2_step = $signed({2'b00, dx2_reg})
                    + $signed({{(SQ_W+1-COORD_W){dx_reg[COORD_W-1]}}, dx_reg, 1'b1});
    assign dy2_step = $signed({2'b00, dy2_reg})
                    + $signed({{(SQ_W+1-COORD_W){dy_reg[COORD_W-1]}}, dy_reg, 1'b1});

    assign dist_sum = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign col_last = (coord_t'({{(COORD_W-CW){1'b0}}, col_reg}) == x1);
    assign row_last = (coord_t'({{(COORD_W-RW){1'b0}}, row_reg}) == y1);

    assign stat.hit  = !ctrl.circle || (dist_sum <= {1'b0, r2_reg});
    assign stat.last = col_last && row_last;
    assign col       = col_reg;
    assign row       = row_reg;

    always_comb
    begin
        r2_next    = r2_reg;
        dx0sq_next = dx0sq_reg;
        dx2_next   = dx2_reg;
        dy2_next   = dy2_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        case (ctrl.op)
            SCAN_SQ_R:
            begin
                r2_next = sq;
            end
            SCAN_SQ_X:
            begin
                dx0sq_next = sq;
            end
            SCAN_LOAD:
            begin
                col_next = x0[CW-1:0];
                row_next = y0[RW-1:0];
                dx_next  = dx0;
                dy_next  = dy0;
                dx2_next = dx0sq_reg;
                dy2_next = sq;
            end
            SCAN_STEP:
            begin
                if (col_last)
                begin
                    col_next = x0[CW-1:0];
                    dx_next  = dx0;
                    dx2_next = dx0sq_reg;
                    row_next = row_reg + RW'(1);
                    dy_next  = dy_reg + coord_t'(1);
                    dy2_next = dy2_step[SQ_W-1:0];
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                    dx_next  = dx_reg + coord_t'(1);
                    dx2_next = dx2_step[SQ_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        r2_reg    <= r2_next;
        dx0sq_reg <= dx0sq_next;
        dx2_reg   <= dx2_next;
        dy2_reg   <= dy2_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
    end

endmodule

/* hdl/shape_fill_raster_engine.sv */
// top level: command sequencer, pixel memory and result register
//
// channel   modport  transfer carries
// cmd       sink     command, pos_x, pos_y, rect_width, rect_height, radius, fill_value
// result    source   read_value, status
//
// after reset the pixel memory is zeroed one pixel a cycle; cmd.ready stays low
// until that pass is done. a fill scans one pixel of its clamped box per cycle,
// set by the single write port. one command is in flight at a time; cmd.ready
// is high only while idle. a finished result waits in its own state if the
// output register is still full.
`include "shape_fill_raster_engine_assert.svh"

module shape_fill_raster_engine import sfr_pkg::*; #(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
    input logic       clk,
    input logic       rst_n,
    sfr_cmd_if.sink   cmd,
    sfr_res_if.source result
);

    localparam int CW        = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
    localparam int RW        = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
    localparam int AW        = CW + RW;
    localparam int MEM_DEPTH = 1 << AW;
    localparam coord_t X_MAX = coord_t'(GRID_WIDTH - 1);
    localparam coord_t Y_MAX = coord_t'(GRID_HEIGHT - 1);

    state_t state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    // captured command
    logic [1:0]        command_reg;
    logic signed [7:0] pos_x_reg;
    logic signed [7:0] pos_y_reg;
    logic [7:0]        width_reg;
    logic [7:0]        height_reg;
    logic [6:0]        radius_reg;
    logic [7:0]        fill_value_reg;
    logic              cmd_xfer;

    // clamped scan box
    coord_t x0_reg, x1_reg, y0_reg, y1_reg;
    coord_t box_x0, box_x1, box_y0, box_y1;
    logic   box_load;
    coord_t px, py, rsz;
    coord_t rect_x0, rect_y0;

    // pending and presented result
    logic [7:0] res_value_reg, res_value_next;
    logic [1:0] res_status_reg, res_status_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_value_reg;
    logic [1:0] out_status_reg;
    logic       out_load;

    // pixel memory
    logic [7:0]    pixel_mem [MEM_DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    rd_data_reg;

    // scanner
    scan_ctrl_t    scan_ctrl;
    scan_stat_t    scan_stat;
    logic [CW-1:0] scan_col;
    logic [RW-1:0] scan_row;
    coord_t        col_ext;

    assign cmd.ready         = (state_reg == ST_IDLE);
    assign cmd_xfer          = cmd.valid && cmd.ready;
    assign result.valid      = out_valid_reg;
    assign result.read_value = out_value_reg;
    assign result.status     = out_status_reg;

    assign px  = coord_t'(pos_x_reg);
    assign py  = coord_t'(pos_y_reg);
    assign rsz = coord_t'({3'b000, radius_reg});

    // rectangle: clamp the corner, then clamp the far end measured from it
    assign rect_x0 = clamp_coord(px, X_MAX);
    assign rect_y0 = clamp_coord(py, Y_MAX);

    always_comb
    begin
        if (command_reg == CMD_CIRCLE)
        begin
            box_x0 = clamp_coord(px - rsz, X_MAX);
            box_x1 = clamp_coord(px + rsz, X_MAX);
            box_y0 = clamp_coord(py - rsz, Y_MAX);
            box_y1 = clamp_coord(py + rsz, Y_MAX);
        end
        else
        begin
            box_x0 = rect_x0;
            box_x1 = clamp_coord(rect_x0 + coord_t'({2'b00, width_reg}) - coord_t'(1), X_MAX);
            box_y0 = rect_y0;
            box_y1 = clamp_coord(rect_y0 + coord_t'({2'b00, height_reg}) - coord_t'(1), Y_MAX);
        end
    end

    assign mem_raddr = {pos_y_reg[RW-1:0], pos_x_reg[CW-1:0]};

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        res_value_next   = res_value_reg;
        res_status_next  = res_status_reg;
        box_load         = 1'b0;
        out_load         = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = {scan_row, scan_col};
        mem_wdata        = fill_value_reg;
        mem_re           = 1'b0;
        scan_ctrl.op     = SCAN_HOLD;
        scan_ctrl.circle = (command_reg == CMD_CIRCLE);
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                res_value_next  = '0;
                res_status_next = STATUS_DONE;
                state_next      = ST_FINISH;
                case (command_reg)
                    CMD_RECT:
                    begin
                        if (width_reg == '0 || height_reg == '0)
                        begin
                            res_status_next = STATUS_ZERO_SIZE;
                        end
                        else
                        begin
                            box_load   = 1'b1;
                            state_next = ST_LOAD;
                        end
                    end
                    CMD_CIRCLE:
                    begin
                        if (radius_reg == '0)
                        begin
                            res_status_next = STATUS_ZERO_SIZE;
                        end
                        else
                        begin
                            box_load   = 1'b1;
                            state_next = ST_SQ_R;
                        end
                    end
                    CMD_READ:
                    begin
                        if (px < 0 || px > X_MAX || py < 0 || py > Y_MAX)
                        begin
                            res_status_next = STATUS_OUTSIDE;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SQ_R:
            begin
                scan_ctrl.op = SCAN_SQ_R;
                state_next   = ST_SQ_X;
            end
            ST_SQ_X:
            begin
                scan_ctrl.op = SCAN_SQ_X;
                state_next   = ST_LOAD;
            end
            ST_LOAD:
            begin
                scan_ctrl.op = SCAN_LOAD;
                state_next   = ST_FILL;
            end
            ST_FILL:
            begin
                // one pixel of the box per cycle
                scan_ctrl.op = SCAN_STEP;
                mem_we       = scan_stat.hit;
                if (scan_stat.last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = ST_READ_WAIT;
            end
            ST_READ_WAIT:
            begin
                res_value_next = rd_data_reg;
                state_next     = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            command_reg    <= cmd.command;
            pos_x_reg      <= cmd.pos_x;
            pos_y_reg      <= cmd.pos_y;
            width_reg      <= cmd.rect_width;
            height_reg     <= cmd.rect_height;
            radius_reg     <= cmd.radius;
            fill_value_reg <= cmd.fill_value;
        end
        if (box_load)
        begin
            x0_reg <= box_x0;
            x1_reg <= box_x1;
            y0_reg <= box_y0;
            y1_reg <= box_y1;
        end
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
        end
    end

    // single write port, single registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pixel_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= pixel_mem[mem_raddr];
        end
    end

    sfr_scan_unit #(
        .CW (CW),
        .RW (RW)
    ) u_scan (
        .clk    (clk),
        .ctrl   (scan_ctrl),
        .x0     (x0_reg),
        .x1     (x1_reg),
        .y0     (y0_reg),
        .y1     (y1_reg),
        .cx     (px),
        .cy     (py),
        .radius (radius_reg),
        .stat   (scan_stat),
        .col    (scan_col),
        .row    (scan_row)
    );

    assign col_ext = coord_t'({{(COORD_W-CW){1'b0}}, scan_col});

    // a taken command holds off the next one: cmd.ready is low in the cycle after
    `SFR_ASSERT_NXT(a_xfer_drops_ready, clk, rst_n, cmd_xfer, !cmd.ready)
    // memory is written only by the clear pass or a fill scan
    `SFR_ASSERT_IMP(a_write_only_scan, clk, rst_n, mem_we, state_reg == ST_CLEAR || state_reg == ST_FILL)
    // the scan column never leaves the clamped box
    `SFR_ASSERT_IMP(a_col_in_box, clk, rst_n, state_reg == ST_FILL, col_ext >= x0_reg && col_ext <= x1_reg)
    // a new result appears only out of the finish state
    `SFR_ASSERT_IMP(a_result_from_finish, clk, rst_n, $rose(out_valid_reg), $past(state_reg == ST_FINISH))

endmodule
